### rtl/amr_pkg.sv
// ----------------------------------------------------------------------------
// amr_pkg
// Shared constants and types of the axis mean reducer.
// ----------------------------------------------------------------------------
package amr_pkg;

  localparam int INNER_MAX_DEF    = 1024;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int SUM_W            = 32;
  localparam int LEN_W            = 16;
  localparam int ICNT_W           = 11;
  localparam int QUEUE_DEPTH      = 4;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_COUNT = 2'd1;

  // classification of one beat along the axis
  typedef struct packed {
    logic first;
    logic last;
  } amr_flags_t;

endpackage

### rtl/amr_ram.sv
// ----------------------------------------------------------------------------
// amr_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module amr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/amr_queue.sv
// ----------------------------------------------------------------------------
// amr_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module amr_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW:0]      wr_ptr_r, rd_ptr_r;
  logic             do_push, do_pop;

  assign empty   = (wr_ptr_r == rd_ptr_r);
  assign full    = (wr_ptr_r[PW] != rd_ptr_r[PW]) && (wr_ptr_r[PW-1:0] == rd_ptr_r[PW-1:0]);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r[PW-1:0]];

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r[PW-1:0]] <= wdata;
    end
  end

endmodule

### rtl/amr_front.sv
// ----------------------------------------------------------------------------
// amr_front
// Accepts sample beats, tracks axis and inner position, tags each beat.
// ----------------------------------------------------------------------------
module amr_front import amr_pkg::*; #(
  parameter int INNER_MAX    = INNER_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  localparam int IW = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1,
  localparam int CW = $clog2(INNER_MAX + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    restart,
  input  logic [LEN_W-1:0]        len,
  input  logic [CW-1:0]           inner,
  input  logic                    in_push,
  input  logic [SAMPLE_WIDTH-1:0] in_sample,
  output logic                    in_full,
  output logic                    q_push,
  output logic [IW-1:0]           q_idx,
  output logic [SAMPLE_WIDTH-1:0] q_sample,
  output amr_flags_t              q_flags,
  input  logic                    q_full
);

  logic [LEN_W-1:0] axis_pos_r, axis_pos_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic             accept, wrap;

  assign in_full  = q_full;
  assign accept   = in_push && !q_full;
  assign q_push   = accept;
  assign q_idx    = idx_r;
  assign q_sample = in_sample;
  assign q_flags.first = (axis_pos_r == '0);
  assign q_flags.last  = ({1'b0, axis_pos_r} + 1'b1) >= {1'b0, len};

  // next position
  always_comb begin
    wrap         = ({1'b0, (CW)'(idx_r)} + 1'b1) >= {1'b0, inner};
    idx_nxt      = wrap ? '0 : idx_r + 1'b1;
    axis_pos_nxt = axis_pos_r;
    if (wrap) begin
      axis_pos_nxt = q_flags.last ? '0 : axis_pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      axis_pos_r <= '0;
      idx_r      <= '0;
    end else if (accept) begin
      axis_pos_r <= axis_pos_nxt;
      idx_r      <= idx_nxt;
    end
  end

endmodule

### rtl/amr_back.sv
// ----------------------------------------------------------------------------
// amr_back
// Accumulator read-modify-write, serial divider and result register.
// ----------------------------------------------------------------------------
module amr_back import amr_pkg::*; #(
  parameter int INNER_MAX    = INNER_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  localparam int IW = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [LEN_W-1:0]        len,
  input  logic                    q_empty,
  input  logic [IW-1:0]           q_idx,
  input  logic [SAMPLE_WIDTH-1:0] q_sample,
  input  amr_flags_t              q_flags,
  output logic                    q_pop,
  output logic                    out_empty,
  output logic [SAMPLE_WIDTH-1:0] out_mean,
  input  logic                    out_pop
);

  typedef enum logic [1:0] {S_IDLE, S_ACC, S_DIV, S_DONE} state_t;

  localparam int DCNT_W = $clog2(SUM_W);
  localparam logic [SUM_W:0] LIM = (SUM_W + 1)'(1) << (SAMPLE_WIDTH - 1);

  state_t                  state_r;
  logic [IW-1:0]           idx_r;
  logic [SAMPLE_WIDTH-1:0] sample_r;
  amr_flags_t              flags_r;
  logic [SUM_W-1:0]        dvd_r;
  logic [LEN_W:0]          rem_r;
  logic                    neg_r;
  logic [DCNT_W-1:0]       cnt_r;
  logic                    out_valid_r;
  logic [SAMPLE_WIDTH-1:0] mean_r;

  logic [SUM_W-1:0]        rdata, acc, mag;
  logic [SUM_W:0]          sum_wide;
  logic [LEN_W:0]          trial;
  logic                    fits;
  logic                    ram_we;
  logic [SUM_W-1:0]        ram_wdata;
  logic [SAMPLE_WIDTH-1:0] mean_nxt;
  logic                    out_free;

  // accumulator store
  amr_ram #(.WIDTH(SUM_W), .DEPTH(INNER_MAX)) u_sum_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .raddr (q_idx),
    .rdata (rdata)
  );

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign out_empty = !out_valid_r;
  assign out_mean  = mean_r;
  assign out_free  = !out_valid_r || out_pop;

  // saturating add, first slice loads the sample
  always_comb begin
    sum_wide = (SUM_W + 1)'($signed(rdata)) + (SUM_W + 1)'($signed(sample_r));
    if (flags_r.first) begin
      acc = SUM_W'($signed(sample_r));
    end else if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      acc = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      acc = sum_wide[SUM_W-1:0];
    end
    mag       = acc[SUM_W-1] ? (~acc + 1'b1) : acc;
    ram_we    = (state_r == S_ACC);
    ram_wdata = flags_r.last ? '0 : acc;
  end

  // one quotient bit per cycle
  always_comb begin
    trial = {rem_r[LEN_W-1:0], dvd_r[SUM_W-1]};
    fits  = trial >= {1'b0, len};
  end

  // sign and saturation of the quotient
  always_comb begin
    if (neg_r) begin
      mean_nxt = ({1'b0, dvd_r} > LIM) ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                       : (~dvd_r[SAMPLE_WIDTH-1:0] + 1'b1);
    end else begin
      mean_nxt = ({1'b0, dvd_r} >= LIM) ? {1'b0, {(SAMPLE_WIDTH-1){1'b1}}}
                                        : dvd_r[SAMPLE_WIDTH-1:0];
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_pop && out_valid_r) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            idx_r    <= q_idx;
            sample_r <= q_sample;
            flags_r  <= q_flags;
            state_r  <= S_ACC;
          end
        end
        S_ACC: begin
          dvd_r   <= mag;
          neg_r   <= acc[SUM_W-1];
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= flags_r.last ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          dvd_r <= {dvd_r[SUM_W-2:0], fits};
          rem_r <= fits ? (trial - {1'b0, len}) : trial;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DCNT_W'(SUM_W - 1)) state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            mean_r  <= mean_nxt;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // a waiting result is not overwritten
  a_mean_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_pop |=> $stable(mean_r))
    else $error("pending mean changed");
  // queue is popped only when the sequencer is free
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == S_ACC)
    else $error("pop outside idle");
  // only last-slice beats enter the divider
  a_div_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> flags_r.last)
    else $error("divide without last slice");
`endif

endmodule

### rtl/axis_mean_reducer.sv
// ----------------------------------------------------------------------------
// axis_mean_reducer
// Streaming mean along one tensor axis with per-position accumulators.
// ----------------------------------------------------------------------------
// Samples enter in memory order on in_push/in_full, one beat per element.
// Each beat updates the accumulator of its inner position; on the last slice
// along the axis a beat also yields the mean on out_mean (out_empty/out_pop).
// Configure axis_length (index 0) and inner_count (index 1) through cfg_we,
// cfg_index and cfg_data while idle; any write restarts the stream at the
// start of an outer block.
// Each beat passes through the back end alone: accumulator RAM read, then add
// and write. A final-slice beat then runs the 32-step serial divider and the
// hand-off of its result before the back end pops the next beat from the queue.
// A 4-entry queue between front and back keeps accepting while the back end
// works; in_full rises when it fills. When the receiver stalls, one result
// waits in the output register and the back end holds its next result.
// Reset clears positions and queue; registers return to 1. The sum store
// needs no clearing since the first slice loads rather than adds.
// ----------------------------------------------------------------------------
module axis_mean_reducer import amr_pkg::*; #(
  parameter int INNER_MAX    = INNER_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_push,
  input  logic [SAMPLE_WIDTH-1:0] in_sample,
  output logic                    in_full,
  output logic                    out_empty,
  output logic [SAMPLE_WIDTH-1:0] out_mean,
  input  logic                    out_pop
);

  localparam int IW = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;
  localparam int CW = $clog2(INNER_MAX + 1);
  localparam int QW = IW + SAMPLE_WIDTH + $bits(amr_flags_t);

  logic [LEN_W-1:0]        axis_len_r, len_eff;
  logic [ICNT_W-1:0]       inner_cnt_r;
  logic [CW-1:0]           inner_eff;
  logic                    q_push, q_full, q_pop, q_empty;
  logic [IW-1:0]           f_idx, b_idx;
  logic [SAMPLE_WIDTH-1:0] f_sample, b_sample;
  amr_flags_t              f_flags, b_flags;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_len_r  <= LEN_W'(1);
      inner_cnt_r <= ICNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AXIS_LENGTH: axis_len_r  <= cfg_data[LEN_W-1:0];
        REG_INNER_COUNT: inner_cnt_r <= cfg_data[ICNT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes
  always_comb begin
    len_eff = (axis_len_r == '0) ? LEN_W'(1) : axis_len_r;
    if (inner_cnt_r == '0) begin
      inner_eff = CW'(1);
    end else if (32'(inner_cnt_r) > 32'(INNER_MAX)) begin
      inner_eff = CW'(INNER_MAX);
    end else begin
      inner_eff = CW'(inner_cnt_r);
    end
  end

  amr_front #(.INNER_MAX(INNER_MAX), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (cfg_we),
    .len       (len_eff),
    .inner     (inner_eff),
    .in_push   (in_push),
    .in_sample (in_sample),
    .in_full   (in_full),
    .q_push    (q_push),
    .q_idx     (f_idx),
    .q_sample  (f_sample),
    .q_flags   (f_flags),
    .q_full    (q_full)
  );

  amr_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({f_idx, f_sample, f_flags}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata ({b_idx, b_sample, b_flags}),
    .empty (q_empty)
  );

  amr_back #(.INNER_MAX(INNER_MAX), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .len       (len_eff),
    .q_empty   (q_empty),
    .q_idx     (b_idx),
    .q_sample  (b_sample),
    .q_flags   (b_flags),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_mean  (out_mean),
    .out_pop   (out_pop)
  );

endmodule

### test/tb_axis_mean_reducer.sv
// ----------------------------------------------------------------------------
// tb_axis_mean_reducer
// Self-checking testbench for the streaming axis mean reducer.
// ----------------------------------------------------------------------------
// Samples are pushed in memory order through in_push/in_full. A model inside
// the bench keeps the accumulators, positions and registers, and works out the
// expected mean for each accepted last-slice beat. A checker compares every
// popped mean with the oldest expected one. Directed tests cover the sample
// extremes and the register corner cases: zero length, zero and oversized
// inner count, writes to an unused index, and one long receiver hold-off.
// Random tests then cover many tensor shapes, with idle cycles on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_axis_mean_reducer;
  import amr_pkg::*;

  // first index past the register list, used to check that spare writes restart
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;
  localparam int INNER_LIM = 1024;
  localparam int SETTLE_CYC = 80;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_push;
  logic [15:0] in_sample;
  logic in_full;
  logic out_empty;
  logic [15:0] out_mean;
  logic out_pop;

  // model state
  int sum_mem [INNER_LIM];
  int unsigned axis_pos;
  int unsigned inner_pos;
  int unsigned axis_len_reg;
  int unsigned inner_cnt_reg;
  logic [15:0] mean_q [$];

  int errors;
  int hold_cycles;
  bit calm;

  axis_mean_reducer uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_push(in_push),
    .in_sample(in_sample),
    .in_full(in_full),
    .out_empty(out_empty),
    .out_mean(out_mean),
    .out_pop(out_pop)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // model of one accepted beat
  task automatic model_beat(input logic signed [15:0] s);
    int unsigned len;
    int unsigned inner;
    int unsigned idx;
    longint acc;
    longint avg;
    len = (axis_len_reg == 0) ? 1 : axis_len_reg;
    inner = (inner_cnt_reg == 0) ? 1 : ((inner_cnt_reg > INNER_LIM) ? INNER_LIM : inner_cnt_reg);
    idx = (inner_pos >= inner) ? 0 : inner_pos;
    acc = (axis_pos == 0) ? longint'(s) : longint'(sum_mem[idx]) + longint'(s);
    if (acc > 64'sh7fffffff) acc = 64'sh7fffffff;
    if (acc < -64'sh80000000) acc = -64'sh80000000;
    if (axis_pos + 1 >= len) begin
      avg = acc / longint'(len);
      if (avg > 32767) avg = 32767;
      if (avg < -32768) avg = -32768;
      mean_q.push_back(avg[15:0]);
      sum_mem[idx] = 0;
    end else begin
      sum_mem[idx] = int'(acc);
    end
    idx++;
    if (idx >= inner) begin
      idx = 0;
      axis_pos++;
      if (axis_pos >= len) axis_pos = 0;
    end
    inner_pos = idx;
  endtask

  // push one sample beat, model it once accepted
  task automatic send_sample(input logic [15:0] s);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 10) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_full) @(posedge clk);
    model_beat(s);
  endtask

  task automatic stop_push;
    @(negedge clk);
    in_push <= 1'b0;
  endtask

  // wait until every expected mean has come out and the back end is quiet
  task automatic drain;
    stop_push();
    while (mean_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // register write while idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_AXIS_LENGTH) axis_len_reg = val;
    else if (idx == REG_INNER_COUNT) inner_cnt_reg = val[ICNT_W-1:0];
    axis_pos = 0;
    inner_pos = 0;
  endtask

  function automatic logic [15:0] rand_sample;
    case ($urandom_range(7))
      0: rand_sample = 16'h7fff;
      1: rand_sample = 16'h8000;
      default: rand_sample = 16'($urandom);
    endcase
  endfunction

  // receiver: random stalls plus a counted hold-off when requested
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= calm ? 1'b1 : ($urandom_range(99) >= 10);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (mean_q.size() == 0) begin
        $display("%0t: unexpected mean beat, expected none, actual %0d",
                 $time, $signed(out_mean));
        errors++;
      end else begin
        if (out_mean !== mean_q[0]) begin
          $display("%0t: mean mismatch, expected %0d, actual %0d",
                   $time, $signed(mean_q[0]), $signed(out_mean));
          errors++;
        end
        void'(mean_q.pop_front());
      end
    end
  end

  // reset values, sample extremes
  task automatic test_defaults;
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'hffff);
    send_sample(16'h0001);
    write_reg(REG_AXIS_LENGTH, 16'd2);
    write_reg(REG_INNER_COUNT, 16'd2);
    send_sample(16'h7fff); send_sample(16'h8000);
    send_sample(16'h7fff); send_sample(16'h8000);
    send_sample(16'hffff); send_sample(16'h0003);
    send_sample(16'hfffe); send_sample(16'h0000);
  endtask

  // register corner cases
  task automatic test_reg_edges;
    write_reg(REG_AXIS_LENGTH, 16'd0);
    write_reg(REG_INNER_COUNT, 16'd0);
    send_sample(16'h1234); send_sample(16'h8001);
    write_reg(REG_AXIS_LENGTH, 16'd3);
    write_reg(REG_INNER_COUNT, 16'd1);
    send_sample(16'h0005); send_sample(16'h0007);
    // spare index: no register, stream restarts
    write_reg(REG_SPARE, 16'hffff);
    send_sample(16'h0004); send_sample(16'h0004); send_sample(16'hfff7);
    // oversized inner count saturates
    write_reg(REG_AXIS_LENGTH, 16'd1);
    write_reg(REG_INNER_COUNT, 16'hffff);
    repeat (6) send_sample(rand_sample());
    // longest axis, partial slice only
    write_reg(REG_AXIS_LENGTH, 16'hffff);
    write_reg(REG_INNER_COUNT, 16'd4);
    repeat (6) send_sample(rand_sample());
  endtask

  // receiver holds off while samples keep coming
  task automatic test_backpressure;
    write_reg(REG_AXIS_LENGTH, 16'd1);
    write_reg(REG_INNER_COUNT, 16'd3);
    hold_cycles = 400;
    repeat (40) send_sample(rand_sample());
  endtask

  // random tensor shapes with random content
  task automatic test_random_shapes;
    int sent;
    int unsigned len;
    int unsigned inner;
    int unsigned nblk;
    int unsigned total;
    sent = 0;
    while (sent < 1050) begin
      case ($urandom_range(9))
        0: len = 0;
        1: len = $urandom_range(20, 40);
        default: len = $urandom_range(1, 6);
      endcase
      case ($urandom_range(9))
        0: inner = 0;
        1: inner = $urandom_range(1500, 2047);
        default: inner = $urandom_range(1, 12);
      endcase
      if (inner > 64) len = 1;
      write_reg(REG_AXIS_LENGTH, 16'(len));
      write_reg(REG_INNER_COUNT, 16'(inner) | (16'($urandom) & 16'hf800));
      if (inner > 64) inner = 12;
      if (len == 0) len = 1;
      if (inner == 0) inner = 1;
      nblk = $urandom_range(1, 3);
      total = nblk * len * inner;
      if (total > 200) total = len * inner;
      // sometimes leave an outer block unfinished
      if ($urandom_range(3) == 0) total += $urandom_range(1, len * inner);
      // keep the item count near its budget
      if (sent + int'(total) > 1050) total = 1050 - sent;
      calm = (sent > 500 && sent < 650);
      repeat (total) send_sample(rand_sample());
      sent += total;
    end
    calm = 1'b0;
  endtask

  // main sequence
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_push = 1'b0;
    in_sample = '0;
    errors = 0;
    hold_cycles = 0;
    calm = 1'b0;
    axis_pos = 0;
    inner_pos = 0;
    axis_len_reg = 1;
    inner_cnt_reg = 1;
    foreach (sum_mem[i]) sum_mem[i] = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_defaults();
    test_reg_edges();
    test_backpressure();
    test_random_shapes();
    drain();

    if (errors == 0) $display("tb_axis_mean_reducer: done, clean");
    else $display("tb_axis_mean_reducer: done, errors");
    $finish;
  end

  // timeout
  initial begin
    #5ms;
    $display("tb_axis_mean_reducer: done, errors");
    $finish;
  end

endmodule
